// ===== design/isbc_pkg.sv =====
// Package for the IMU still-bias calibrator: widths, codes, FSM states,
// lane control struct, output saturation helpers and a magnitude helper. No dependencies.
`default_nettype none
package isbc_pkg;

  localparam int AXW   = 24;  // sensor axis sample
  localparam int NRMW  = 24;  // accel norm
  localparam int SQW   = 48;  // sum of squares
  localparam int LVW   = 25;  // lane value, signed
  localparam int SUMW  = 38;  // lane sum, signed
  localparam int SPRW  = 26;  // lane spread
  localparam int CNTW  = 14;  // sample counters
  localparam int LIMW  = 23;  // config limits
  localparam int DVDW  = 43;  // divider dividend
  localparam int DVSW  = 31;  // divider divisor
  localparam int BIASW = 20;
  localparam int MNW   = 20;
  localparam int SCW   = 18;
  localparam int TMPW  = 12;
  localparam int FRAC_BITS = 16;

  localparam logic [CNTW-1:0]       MAX_SAMPLES  = CNTW'(8192);
  localparam logic [CNTW-1:0]       SPR_RESET    = CNTW'(6000);
  localparam logic [SCW-1:0]        QONE         = SCW'(1 << FRAC_BITS);
  localparam logic signed [LVW-1:0] Q_GRAVITY    = LVW'((98 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [TMPW-1:0] DEFAULT_TEMP = TMPW'(320);
  localparam logic [DVDW-1:0]       SCALE_NUM    = DVDW'(981) << (2 * FRAC_BITS);
  localparam logic [NRMW+3:0]       TINY_NORM10  = (NRMW+4)'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_REJECT = 3'd1,
    ST_MOTION = 3'd2,
    ST_RETRY  = 3'd3,
    ST_DONE   = 3'd4,
    ST_EMPTY  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_SPR  = 3'd0,
    REG_NLO  = 3'd1,
    REG_NHI  = 3'd2,
    REG_GABS = 3'd3,
    REG_NSPR = 3'd4,
    REG_GSPR = 3'd5,
    REG_GTOL = 3'd6,
    REG_OFS  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ADD,
    S_SQRT,
    S_CHK,
    S_MOT,
    S_LIMIT,
    S_DSTART,
    S_DWAIT,
    S_SCALE,
    S_FINAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic upd;
    logic first;
    logic clr_sum;
    logic clr_spread;
  } lane_ctl_t;

  function automatic logic signed [BIASW-1:0] sat_bias(input logic signed [LVW-1:0] v);
    logic signed [LVW-1:0] hi;
    logic signed [LVW-1:0] lo;
    hi = LVW'((1 << (BIASW - 1)) - 1);
    lo = -LVW'(1 << (BIASW - 1));
    if (v > hi) return hi[BIASW-1:0];
    else if (v < lo) return lo[BIASW-1:0];
    else return v[BIASW-1:0];
  endfunction

  function automatic logic [MNW-1:0] sat_norm(input logic [NRMW-1:0] v);
    if (v > NRMW'((1 << MNW) - 1)) return {MNW{1'b1}};
    else return v[MNW-1:0];
  endfunction

  function automatic logic [SCW-1:0] sat_scale(input logic [DVDW-1:0] v);
    if (v > DVDW'((1 << SCW) - 1)) return {SCW{1'b1}};
    else return v[SCW-1:0];
  endfunction

  function automatic logic [AXW-1:0] mag24(input logic signed [AXW-1:0] v);
    if (v[AXW-1]) return ~v + AXW'(1);
    else return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/isbc_isqrt.sv =====
// Bit-serial floor integer square root, one result bit per cycle.
// Depends on isbc_pkg.
`default_nettype none
module isbc_isqrt
  import isbc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [SQW-1:0]  radicand,
  output logic                 done,
  output logic [NRMW-1:0]      root
);

  logic [SQW-1:0]  x_r;
  logic [NRMW+2:0] rem_r;
  logic [NRMW-1:0] root_r;
  logic [4:0]      cnt_r;
  logic            run_r;
  logic            done_r;
  logic [NRMW+2:0] rem_sh;
  logic [NRMW+2:0] trial;

  assign rem_sh = {rem_r[NRMW:0], x_r[SQW-1:SQW-2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'(NRMW - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      x_r <= {x_r[SQW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[NRMW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[NRMW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== design/isbc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, shared by all
// end-of-round means and the accel scale. Depends on isbc_pkg.
`default_nettype none
module isbc_div
  import isbc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DVDW-1:0] dividend,
  input  wire logic [DVSW-1:0] divisor,
  output logic                 done,
  output logic [DVDW-1:0]      quot
);

  logic [DVDW-1:0] q_r;
  logic [DVSW-1:0] rem_r;
  logic [DVSW-1:0] dvs_r;
  logic [5:0]      cnt_r;
  logic            run_r;
  logic            done_r;
  logic [DVSW:0]   trial;

  assign trial = {rem_r, q_r[DVDW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'(DVDW - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= DVSW'(trial - {1'b0, dvs_r});
        q_r   <= {q_r[DVDW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DVSW-1:0];
        q_r   <= {q_r[DVDW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ===== design/isbc_lane.sv =====
// One accumulation lane: running sum, min/max and spread of one quantity.
// Depends on isbc_pkg.
`default_nettype none
module isbc_lane
  import isbc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lane_ctl_t             ctl,
  input  wire logic signed [LVW-1:0] val,
  output logic signed [SUMW-1:0]     sum,
  output logic [SPRW-1:0]            spread
);

  logic signed [LVW-1:0]  max_r;
  logic signed [LVW-1:0]  min_r;
  logic signed [SUMW-1:0] sum_r;
  logic [SPRW-1:0]        spread_r;
  logic signed [LVW-1:0]  max_nxt;
  logic signed [LVW-1:0]  min_nxt;
  logic signed [SPRW-1:0] diff;

  always_comb begin
    max_nxt = (ctl.first || val > max_r) ? val : max_r;
    min_nxt = (ctl.first || val < min_r) ? val : min_r;
    diff    = SPRW'(max_nxt) - SPRW'(min_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      spread_r <= '0;
    end else begin
      if (ctl.clr_sum) sum_r <= '0;
      else if (ctl.upd) sum_r <= sum_r + SUMW'(val);
      if (ctl.clr_spread) spread_r <= '0;
      else if (ctl.upd) spread_r <= diff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  assign sum    = sum_r;
  assign spread = spread_r;

endmodule
`default_nettype wire

// ===== design/imu_still_bias_calibrator.sv =====
// IMU still-bias calibrator top: control FSM, config registers, held results.
// Uses isbc_pkg, isbc_lane (norm + three gyro lanes), isbc_isqrt, isbc_div.
//
// One item is processed at a time. A sample item with both reads good goes
// through squaring, summing into the square root unit, the bit-serial square
// root, then the limit check, the motion check, the round check, the output
// load and the return to idle before the next input transfer. A failed read
// goes straight to the round check. The last attempt of a round with valid
// samples adds four or five passes through the shared serial divider: the norm
// mean, three gyro means and, if the mean norm is not tiny, the accel scale.
// Start items and items after the calibration finished go straight to the
// output load. A result waits in the output register, and the block can take
// and work on the next item meanwhile; it stalls at its output load until the
// waiting result is taken.
`default_nettype none
module imu_still_bias_calibrator
  import isbc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_func,
  input  wire logic                   in_accel_ok,
  input  wire logic                   in_gyro_ok,
  input  wire logic signed [AXW-1:0]  in_accel_x,
  input  wire logic signed [AXW-1:0]  in_accel_y,
  input  wire logic signed [AXW-1:0]  in_accel_z,
  input  wire logic signed [AXW-1:0]  in_gyro_x,
  input  wire logic signed [AXW-1:0]  in_gyro_y,
  input  wire logic signed [AXW-1:0]  in_gyro_z,
  input  wire logic                   in_temp_ok,
  input  wire logic signed [TMPW-1:0] in_sensor_temp,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  out_status,
  output logic [CNTW-1:0]             out_valid_count,
  output logic signed [BIASW-1:0]     out_bias_x,
  output logic signed [BIASW-1:0]     out_bias_y,
  output logic signed [BIASW-1:0]     out_bias_z,
  output logic [MNW-1:0]              out_mean_norm,
  output logic [SCW-1:0]              out_accel_scale,
  output logic signed [TMPW-1:0]      out_cal_temp,
  output logic                        out_calibrated,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [LIMW-1:0]        cfg_data
);

  state_t state_r, state_nxt;

  logic [CNTW-1:0] spr_r;
  logic [LIMW-1:0] nlo_r, nhi_r, gabs_r, nspr_r, gspr_r, gtol_r, ofs_r;

  logic signed [AXW-1:0] ax_r [3];
  logic signed [AXW-1:0] gx_r [3];
  logic                  tok_r;
  logic signed [TMPW-1:0] temp_r;
  logic [SQW-1:0]        sq_r [3];
  logic [SQW-1:0]        rad;

  logic [CNTW-1:0] att_r, good_r, cnt_r;
  status_t         st_r, hstat_r;
  logic            fin_r, cal_r;
  logic [2:0]      sel_r;
  logic [NRMW-1:0] mean_n_r;
  logic signed [LVW-1:0] mean_g_r [3];
  logic [DVSW-1:0] den_r;
  logic [SCW-1:0]  scale_r;

  logic signed [BIASW-1:0] bias_r [3];
  logic [MNW-1:0]          hnorm_r;
  logic [SCW-1:0]          hscale_r;
  logic signed [TMPW-1:0]  htemp_r;

  logic                    ov_r;
  status_t                 ost_r;
  logic [CNTW-1:0]         ocnt_r;
  logic signed [BIASW-1:0] obias_r [3];
  logic [MNW-1:0]          onorm_r;
  logic [SCW-1:0]          oscale_r;
  logic signed [TMPW-1:0]  otemp_r;
  logic                    ocal_r;

  lane_ctl_t lane_ctl;
  logic signed [SUMW-1:0] nsum;
  logic [SPRW-1:0]        nspread;
  logic signed [SUMW-1:0] gsum [3];
  logic [SPRW-1:0]        gspread [3];

  logic            sqrt_start, sqrt_done;
  logic [NRMW-1:0] norm;
  logic            div_start, div_done;
  logic [DVDW-1:0] div_dvd, div_quot;
  logic [DVSW-1:0] div_dvs;

  logic            in_xfer, emit_ok, sample_bad, motion_bad, round_end, final_bad;
  logic [CNTW-1:0] lim;
  logic [SUMW-1:0] gmag;
  logic signed [SUMW-1:0] gsel;
  logic [NRMW+3:0] norm10;
  logic signed [LVW-1:0]  gdiff;
  logic [LVW-1:0]  gdiff_mag;
  logic [NRMW-1:0] qmag;
  logic            qneg;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign emit_ok   = !ov_r || out_ready;
  assign rad       = sq_r[0] + sq_r[1] + sq_r[2];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r  <= SPR_RESET;
      nlo_r  <= LIMW'(5 << FRAC_BITS);
      nhi_r  <= LIMW'(15 << FRAC_BITS);
      gabs_r <= LIMW'(5 << FRAC_BITS);
      nspr_r <= LIMW'((1 << FRAC_BITS) / 2);
      gspr_r <= LIMW'(15 * (1 << FRAC_BITS) / 100);
      gtol_r <= LIMW'((1 << FRAC_BITS) / 2);
      ofs_r  <= LIMW'((1 << FRAC_BITS) / 100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SPR:  spr_r  <= cfg_data[CNTW-1:0];
        REG_NLO:  nlo_r  <= cfg_data;
        REG_NHI:  nhi_r  <= cfg_data;
        REG_GABS: gabs_r <= cfg_data;
        REG_NSPR: nspr_r <= cfg_data;
        REG_GSPR: gspr_r <= cfg_data;
        REG_GTOL: gtol_r <= cfg_data;
        REG_OFS:  ofs_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // lanes
  isbc_lane u_nlane (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .val    ($signed({1'b0, norm})),
    .sum    (nsum),
    .spread (nspread)
  );

  for (genvar j = 0; j < 3; j++) begin : g_glane
    isbc_lane u_glane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .val    (LVW'(gx_r[j])),
      .sum    (gsum[j]),
      .spread (gspread[j])
    );
  end

  isbc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (rad),
    .done     (sqrt_done),
    .root     (norm)
  );

  isbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  // checks and muxes
  always_comb begin
    sample_bad = (norm > {1'b0, nhi_r}) || (norm < {1'b0, nlo_r});
    for (int j = 0; j < 3; j++)
      if (mag24(gx_r[j]) > {1'b0, gabs_r}) sample_bad = 1'b1;

    motion_bad = nspread > SPRW'(nspr_r);
    for (int j = 0; j < 3; j++)
      if (gspread[j] > SPRW'(gspr_r)) motion_bad = 1'b1;

    if (spr_r == '0) lim = CNTW'(1);
    else if (spr_r > MAX_SAMPLES) lim = MAX_SAMPLES;
    else lim = spr_r;
    round_end = !(att_r < lim);

    unique case (sel_r)
      3'd1:    gsel = gsum[0];
      3'd2:    gsel = gsum[1];
      default: gsel = gsum[2];
    endcase
    gmag = gsel[SUMW-1] ? SUMW'(-gsel) : SUMW'(gsel);
    qneg = gsel[SUMW-1];
    qmag = div_quot[NRMW-1:0];

    if (sel_r == 3'd0) begin
      div_dvd = DVDW'(nsum[SUMW-1:0]);
      div_dvs = DVSW'(good_r);
    end else if (sel_r == 3'd4) begin
      div_dvd = SCALE_NUM + DVDW'(den_r >> 1);
      div_dvs = den_r;
    end else begin
      div_dvd = DVDW'(gmag);
      div_dvs = DVSW'(good_r);
    end

    norm10    = (NRMW+4)'(mean_n_r) * (NRMW+4)'(10);
    gdiff     = $signed({1'b0, mean_n_r}) - Q_GRAVITY;
    gdiff_mag = gdiff[LVW-1] ? LVW'(-gdiff) : LVW'(gdiff);
    final_bad = motion_bad || (gdiff_mag > LVW'(gtol_r));
    for (int j = 0; j < 3; j++) begin
      if ((mean_g_r[j][LVW-1] ? LVW'(-mean_g_r[j]) : LVW'(mean_g_r[j])) > LVW'(ofs_r))
        final_bad = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_func || fin_r) state_nxt = S_EMIT;
          else if (in_accel_ok && in_gyro_ok) state_nxt = S_SQ;
          else state_nxt = S_LIMIT;
        end
      end
      S_SQ:   state_nxt = S_ADD;
      S_ADD:  state_nxt = S_SQRT;
      S_SQRT: if (sqrt_done) state_nxt = S_CHK;
      S_CHK:  state_nxt = sample_bad ? S_LIMIT : S_MOT;
      S_MOT:  state_nxt = S_LIMIT;
      S_LIMIT: begin
        if (!round_end || good_r == '0) state_nxt = S_EMIT;
        else state_nxt = S_DSTART;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          if (sel_r == 3'd4) state_nxt = S_FINAL;
          else if (sel_r == 3'd3) state_nxt = S_SCALE;
          else state_nxt = S_DSTART;
        end
      end
      S_SCALE: state_nxt = (norm10 > TINY_NORM10) ? S_DSTART : S_FINAL;
      S_FINAL: state_nxt = S_EMIT;
      S_EMIT:  if (emit_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    sqrt_start = (state_r == S_ADD);
    div_start  = (state_r == S_DSTART);
    lane_ctl   = '0;
    unique case (state_r)
      S_IDLE: begin
        lane_ctl.clr_sum    = in_xfer && in_func;
        lane_ctl.clr_spread = in_xfer && in_func;
      end
      S_CHK: begin
        lane_ctl.upd   = !sample_bad;
        lane_ctl.first = (good_r == '0);
      end
      S_MOT:   lane_ctl.clr_sum = motion_bad;
      S_FINAL: begin
        lane_ctl.clr_sum    = final_bad;
        lane_ctl.clr_spread = final_bad;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      att_r   <= '0;
      good_r  <= '0;
      fin_r   <= 1'b0;
      cal_r   <= 1'b0;
      hstat_r <= ST_ACCEPT;
      ov_r    <= 1'b0;
      for (int j = 0; j < 3; j++) bias_r[j] <= '0;
      hnorm_r  <= '0;
      hscale_r <= '0;
      htemp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && emit_ok) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_func) begin
              att_r   <= '0;
              good_r  <= '0;
              fin_r   <= 1'b0;
              cal_r   <= 1'b0;
              hstat_r <= ST_ACCEPT;
              for (int j = 0; j < 3; j++) bias_r[j] <= '0;
              hnorm_r  <= '0;
              hscale_r <= '0;
              htemp_r  <= '0;
            end else if (!fin_r) begin
              att_r <= att_r + CNTW'(1);
            end
          end
        end
        S_CHK: if (!sample_bad) good_r <= good_r + CNTW'(1);
        S_MOT: if (motion_bad) good_r <= '0;
        S_LIMIT: begin
          if (round_end && good_r == '0) begin
            for (int j = 0; j < 3; j++) bias_r[j] <= '0;
            hnorm_r  <= '0;
            hscale_r <= QONE;
            cal_r    <= 1'b0;
            hstat_r  <= ST_EMPTY;
            fin_r    <= 1'b1;
          end
        end
        S_FINAL: begin
          for (int j = 0; j < 3; j++) bias_r[j] <= sat_bias(mean_g_r[j]);
          hnorm_r  <= sat_norm(mean_n_r);
          hscale_r <= scale_r;
          htemp_r  <= tok_r ? temp_r : DEFAULT_TEMP;
          if (final_bad) begin
            cal_r  <= 1'b0;
            good_r <= '0;
            att_r  <= '0;
          end else begin
            cal_r   <= 1'b1;
            hstat_r <= ST_DONE;
            fin_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ax_r[0] <= in_accel_x;
          ax_r[1] <= in_accel_y;
          ax_r[2] <= in_accel_z;
          gx_r[0] <= in_gyro_x;
          gx_r[1] <= in_gyro_y;
          gx_r[2] <= in_gyro_z;
          tok_r   <= in_temp_ok;
          temp_r  <= in_sensor_temp;
          if (in_func) begin
            st_r  <= ST_ACCEPT;
            cnt_r <= '0;
          end else if (fin_r) begin
            st_r  <= hstat_r;
            cnt_r <= good_r;
          end else begin
            st_r  <= ST_REJECT;
            cnt_r <= good_r;
          end
        end
      end
      S_SQ: begin
        for (int j = 0; j < 3; j++)
          sq_r[j] <= SQW'(mag24(ax_r[j])) * SQW'(mag24(ax_r[j]));
      end
      S_MOT: st_r <= motion_bad ? ST_MOTION : ST_ACCEPT;
      S_LIMIT: begin
        sel_r <= 3'd0;
        if (!round_end) begin
          cnt_r <= good_r;
        end else if (good_r == '0) begin
          st_r  <= ST_EMPTY;
          cnt_r <= '0;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          if (sel_r == 3'd0) mean_n_r <= qmag;
          else if (sel_r == 3'd1) mean_g_r[0] <= qneg ? -LVW'(qmag) : LVW'(qmag);
          else if (sel_r == 3'd2) mean_g_r[1] <= qneg ? -LVW'(qmag) : LVW'(qmag);
          else if (sel_r == 3'd3) mean_g_r[2] <= qneg ? -LVW'(qmag) : LVW'(qmag);
          else scale_r <= sat_scale(div_quot);
          if (sel_r != 3'd4) sel_r <= sel_r + 3'd1;
        end
      end
      S_SCALE: begin
        den_r <= DVSW'(mean_n_r) * DVSW'(100);
        if (!(norm10 > TINY_NORM10)) scale_r <= QONE;
      end
      S_FINAL: begin
        st_r  <= final_bad ? ST_RETRY : ST_DONE;
        cnt_r <= good_r;
      end
      S_EMIT: begin
        if (emit_ok) begin
          ost_r    <= st_r;
          ocnt_r   <= cnt_r;
          for (int j = 0; j < 3; j++) obias_r[j] <= bias_r[j];
          onorm_r  <= hnorm_r;
          oscale_r <= hscale_r;
          otemp_r  <= htemp_r;
          ocal_r   <= cal_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_valid_count = ocnt_r;
  assign out_bias_x      = obias_r[0];
  assign out_bias_y      = obias_r[1];
  assign out_bias_z      = obias_r[2];
  assign out_mean_norm   = onorm_r;
  assign out_accel_scale = oscale_r;
  assign out_cal_temp    = otemp_r;
  assign out_calibrated  = ocal_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for imu_still_bias_calibrator: directed and random sample streams,
// an in-bench predictor with a result scoreboard class. Depends on isbc_pkg and imu_still_bias_calibrator.
`default_nettype none
module tb_top;
  import isbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit                      func;
    bit                      aok;
    bit                      gok;
    logic signed [AXW-1:0]   acc[3];
    logic signed [AXW-1:0]   gyr[3];
    bit                      tok;
    logic signed [TMPW-1:0]  temp;
  } imu_item_t;

  typedef struct {
    status_t                 st;
    logic [CNTW-1:0]         cnt;
    logic signed [BIASW-1:0] bias[3];
    logic [MNW-1:0]          nrm;
    logic [SCW-1:0]          scale;
    logic signed [TMPW-1:0]  temp;
    bit                      cal;
  } cal_result_t;

  localparam longint Q1       = 64'd1 << 16;
  localparam longint Q100     = 100 * Q1;
  localparam longint QGRAVITY = 642253;
  localparam int     TEMP40   = 320;

  class calib_scoreboard;
    cal_result_t pending[$];
    int errors;
    int seen[6];
    int unsigned spr, nlo, nhi, gabs, nsprl, gsprl, gtol, ofsl;
    longint unsigned norm_sum;
    longint gsum[3], nmax, nmin, gmax[3], gmin[3], nspread, gspread[3];
    longint hbias[3], hnorm, hscale, htemp;
    int unsigned good, tries;
    status_t hstat;
    bit cal, finished;

    function new();
      spr = 6000; nlo = 5 * Q1; nhi = 15 * Q1; gabs = 5 * Q1;
      nsprl = Q1 / 2; gsprl = 15 * Q1 / 100; gtol = Q1 / 2; ofsl = Q1 / 100;
      clear_all();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [LIMW-1:0] d);
      case (idx)
        REG_SPR:  spr = d[CNTW-1:0];
        REG_NLO:  nlo = d;
        REG_NHI:  nhi = d;
        REG_GABS: gabs = d;
        REG_NSPR: nsprl = d;
        REG_GSPR: gsprl = d;
        REG_GTOL: gtol = d;
        REG_OFS:  ofsl = d;
      endcase
    endfunction

    function longint unsigned absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void clear_round();
      norm_sum = 0; good = 0; nmax = 0; nmin = Q100;
      for (int j = 0; j < 3; j++) begin
        gsum[j] = 0; gmax[j] = -Q100; gmin[j] = Q100;
      end
    endfunction

    function void clear_all();
      clear_round();
      tries = 0; nspread = 0;
      for (int j = 0; j < 3; j++) begin
        gspread[j] = 0; hbias[j] = 0;
      end
      hnorm = 0; hscale = 0; htemp = 0; hstat = ST_ACCEPT; cal = 0; finished = 0;
    endfunction

    function void post(status_t st, int unsigned cnt);
      cal_result_t r;
      r.st = st;
      r.cnt = cnt[CNTW-1:0];
      for (int j = 0; j < 3; j++) r.bias[j] = BIASW'(clamp(hbias[j], -524288, 524287));
      r.nrm = MNW'(clamp(hnorm, 0, 20'hFFFFF));
      r.scale = SCW'(clamp(hscale, 0, 18'h3FFFF));
      r.temp = htemp[TMPW-1:0];
      r.cal = cal;
      pending.push_back(r);
    endfunction

    function void note_item(imu_item_t it);
      longint unsigned sq, nrm, q, den;
      longint g[3], m[3], mn, n;
      bit bad;
      int unsigned lim;
      status_t st;
      if (it.func) begin
        clear_all();
        post(ST_ACCEPT, 0);
        return;
      end
      if (finished) begin
        post(hstat, good);
        return;
      end
      tries++;
      st = ST_REJECT;
      if (it.aok && it.gok) begin
        sq = 0;
        for (int j = 0; j < 3; j++) begin
          sq += absv(it.acc[j]) * absv(it.acc[j]);
          g[j] = it.gyr[j];
        end
        nrm = root(sq);
        bad = nrm > nhi || nrm < nlo;
        for (int j = 0; j < 3; j++) if (absv(g[j]) > gabs) bad = 1;
        if (!bad) begin
          n = nrm;
          norm_sum += nrm;
          for (int j = 0; j < 3; j++) gsum[j] += g[j];
          good++;
          if (good == 1) begin
            nmax = n; nmin = n;
            for (int j = 0; j < 3; j++) begin
              gmax[j] = g[j]; gmin[j] = g[j];
            end
          end else begin
            if (n > nmax) nmax = n;
            if (n < nmin) nmin = n;
            for (int j = 0; j < 3; j++) begin
              if (g[j] > gmax[j]) gmax[j] = g[j];
              if (g[j] < gmin[j]) gmin[j] = g[j];
            end
          end
          nspread = nmax - nmin;
          bad = nspread > longint'(nsprl);
          for (int j = 0; j < 3; j++) begin
            gspread[j] = gmax[j] - gmin[j];
            if (gspread[j] > longint'(gsprl)) bad = 1;
          end
          st = ST_ACCEPT;
          if (bad) begin
            clear_round();
            st = ST_MOTION;
          end
        end
      end
      lim = spr == 0 ? 1 : (spr > 8192 ? 8192 : spr);
      if (tries < lim) begin
        post(st, good);
        return;
      end
      if (good == 0) begin
        for (int j = 0; j < 3; j++) hbias[j] = 0;
        hnorm = 0; hscale = Q1; cal = 0; hstat = ST_EMPTY; finished = 1;
        post(ST_EMPTY, 0);
        return;
      end
      mn = norm_sum / good;
      for (int j = 0; j < 3; j++) begin
        q = absv(gsum[j]) / good;
        m[j] = gsum[j] < 0 ? -longint'(q) : longint'(q);
      end
      htemp = it.tok ? longint'(it.temp) : TEMP40;
      hnorm = mn;
      for (int j = 0; j < 3; j++) hbias[j] = m[j];
      if (mn * 10 > Q1) begin
        den = mn * 100;
        hscale = ((64'd981 << 32) + den / 2) / den;
      end else begin
        hscale = Q1;
      end
      bad = nspread > longint'(nsprl);
      if (absv(mn - QGRAVITY) > gtol) bad = 1;
      for (int j = 0; j < 3; j++) begin
        if (gspread[j] > longint'(gsprl)) bad = 1;
        if (absv(m[j]) > ofsl) bad = 1;
      end
      if (bad) begin
        cal = 0;
        post(ST_RETRY, good);
        clear_round();
        tries = 0; nspread = 0;
        for (int j = 0; j < 3; j++) gspread[j] = 0;
        return;
      end
      cal = 1; hstat = ST_DONE; finished = 1;
      post(ST_DONE, good);
    endfunction

    function void check(cal_result_t got);
      cal_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected, status %0d", got.st);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.st <= ST_EMPTY) seen[got.st]++;
      if (got.st !== exp_r.st) begin
        $error("status: expected %0d got %0d", exp_r.st, got.st); errors++;
      end
      if (got.cnt !== exp_r.cnt) begin
        $error("valid_count: expected %0d got %0d", exp_r.cnt, got.cnt); errors++;
      end
      for (int j = 0; j < 3; j++)
        if (got.bias[j] !== exp_r.bias[j]) begin
          $error("bias[%0d]: expected %0d got %0d", j, exp_r.bias[j], got.bias[j]);
          errors++;
        end
      if (got.nrm !== exp_r.nrm) begin
        $error("mean_norm: expected %0d got %0d", exp_r.nrm, got.nrm); errors++;
      end
      if (got.scale !== exp_r.scale) begin
        $error("accel_scale: expected %0d got %0d", exp_r.scale, got.scale); errors++;
      end
      if (got.temp !== exp_r.temp) begin
        $error("cal_temp: expected %0d got %0d", exp_r.temp, got.temp); errors++;
      end
      if (got.cal !== exp_r.cal) begin
        $error("calibrated: expected %0d got %0d", exp_r.cal, got.cal); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_func, in_accel_ok, in_gyro_ok, in_temp_ok;
  logic signed [AXW-1:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [AXW-1:0] in_gyro_x, in_gyro_y, in_gyro_z;
  logic signed [TMPW-1:0] in_sensor_temp;
  logic out_valid, out_ready, out_calibrated;
  logic [2:0] out_status;
  logic [CNTW-1:0] out_valid_count;
  logic signed [BIASW-1:0] out_bias_x, out_bias_y, out_bias_z;
  logic [MNW-1:0] out_mean_norm;
  logic [SCW-1:0] out_accel_scale;
  logic signed [TMPW-1:0] out_cal_temp;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [LIMW-1:0] cfg_data;

  imu_still_bias_calibrator uut (.*);

  calib_scoreboard sb = new();
  int n_items, n_results;
  int gyro_bias[3];
  int gyro_noise;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    cal_result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.st = status_t'(out_status);
      r.cnt = out_valid_count;
      r.bias[0] = out_bias_x; r.bias[1] = out_bias_y; r.bias[2] = out_bias_z;
      r.nrm = out_mean_norm; r.scale = out_accel_scale;
      r.temp = out_cal_temp; r.cal = out_calibrated;
      sb.check(r);
      n_results++;
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int k;
    bit held;
    held = 0;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && n_results >= 150) begin
        held = 1;
        out_ready = 0;
        repeat (600) @(negedge clk);
        out_ready = 1;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 65) out_ready = 1;
        else if (k < 95) begin
          out_ready = 0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
          out_ready = 1;
        end else begin
          out_ready = 0;
          repeat ($urandom_range(10, 80)) @(negedge clk);
          out_ready = 1;
        end
      end
    end
  end

  task automatic idle_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k >= 60) begin
      in_valid = 0;
      repeat (k < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk);
    end
  endtask

  task automatic send(imu_item_t it);
    in_valid = 1;
    in_func = it.func; in_accel_ok = it.aok; in_gyro_ok = it.gok;
    in_accel_x = it.acc[0]; in_accel_y = it.acc[1]; in_accel_z = it.acc[2];
    in_gyro_x = it.gyr[0]; in_gyro_y = it.gyr[1]; in_gyro_z = it.gyr[2];
    in_temp_ok = it.tok; in_sensor_temp = it.temp;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    n_items++;
    @(negedge clk);
    in_valid = 0;
    idle_gap();
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [LIMW-1:0] d);
    cfg_valid = 1; cfg_index = idx; cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic imu_item_t base_item();
    imu_item_t it;
    it.func = 0; it.aok = 1; it.gok = 1; it.tok = $urandom_range(0, 1);
    it.temp = $urandom_range(0, 1520) - 320;
    for (int j = 0; j < 3; j++) begin
      it.acc[j] = 0; it.gyr[j] = 0;
    end
    return it;
  endfunction

  function automatic imu_item_t still_item();
    imu_item_t it;
    int ax;
    it = base_item();
    ax = $urandom_range(0, 2);
    for (int j = 0; j < 3; j++) begin
      it.acc[j] = int'($urandom_range(0, 3000)) - 1500;
      it.gyr[j] = gyro_bias[j] + int'($urandom_range(0, 2 * gyro_noise)) - gyro_noise;
    end
    it.acc[ax] = 642253 + int'($urandom_range(0, 6000)) - 3000;
    if ($urandom_range(0, 1)) it.acc[ax] = -it.acc[ax];
    return it;
  endfunction

  function automatic imu_item_t noise_item();
    imu_item_t it;
    it = base_item();
    it.aok = $urandom_range(0, 3) != 0;
    it.gok = $urandom_range(0, 3) != 0;
    for (int j = 0; j < 3; j++) begin
      it.acc[j] = $urandom;
      it.gyr[j] = $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 8000)) - 4000;
    end
    return it;
  endfunction

  function automatic imu_item_t start_item();
    imu_item_t it;
    it = noise_item();
    it.func = 1;
    return it;
  endfunction

  initial begin
    imu_item_t it;
    logic [CNTW-1:0] spr;
    rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_index = REG_SPR; cfg_data = 0;
    in_func = 0; in_accel_ok = 0; in_gyro_ok = 0; in_temp_ok = 0; in_sensor_temp = 0;
    in_accel_x = 0; in_accel_y = 0; in_accel_z = 0;
    in_gyro_x = 0; in_gyro_y = 0; in_gyro_z = 0;
    n_items = 0; n_results = 0;
    gyro_bias = '{100, -100, 50};
    gyro_noise = 200;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed, reset settings
    send(start_item());
    send(still_item());
    it = base_item();
    it.acc = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
    send(it);
    it.acc = '{-24'sh800000, -24'sh800000, -24'sh800000};
    it.gyr = '{24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF};
    send(it);
    it = still_item(); it.aok = 0; send(it);
    it = still_item(); it.gok = 0; send(it);
    it = still_item(); it.aok = 0; it.gok = 0; send(it);
    send(base_item());
    it = still_item(); it.gyr[1] = 5 * Q1 + 1; send(it);
    it = still_item(); it.gyr[2] = 24'sh010000; send(it);
    it = still_item(); it.acc = '{0, 0, 9 * Q1}; send(it);
    drain();

    // short rounds: temperature extremes, empty round, finished repeats
    write_reg(REG_SPR, 1);
    it = still_item(); it.tok = 1; it.temp = -320; send(it);
    send(still_item());
    send(start_item());
    it = still_item(); it.tok = 1; it.temp = 1200; send(it);
    send(start_item());
    it = noise_item(); it.aok = 0; send(it);
    send(still_item());
    send(start_item());
    drain();
    write_reg(REG_SPR, 0);
    it = still_item(); it.tok = 0; send(it);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: spr = 14'h3FFF;
        1: spr = 14'd8192;
        default: spr = $urandom_range(2, 24);
      endcase
      gyro_noise = $urandom_range(20, 900);
      for (int j = 0; j < 3; j++) gyro_bias[j] = int'($urandom_range(0, 1200)) - 600;
      write_reg(REG_SPR, spr);
      if (p == 2) begin
        for (int r = 1; r < 8; r++) write_reg(cfg_idx_t'(r), 0);
      end else if (p == 3) begin
        for (int r = 1; r < 8; r++) write_reg(cfg_idx_t'(r), 23'h7FFFFF);
      end else begin
        write_reg(REG_NLO, $urandom_range(4, 6) * Q1);
        write_reg(REG_NHI, $urandom_range(14, 16) * Q1);
        write_reg(REG_GABS, $urandom_range(1000, 5 * Q1));
        write_reg(REG_NSPR, $urandom_range(2000, 40000));
        write_reg(REG_GSPR, $urandom_range(300, 4000));
        write_reg(REG_GTOL, $urandom_range(2000, 40000));
        write_reg(REG_OFS, $urandom_range(100, 1000));
      end
      send(start_item());
      for (int i = 0; i < 56; i++) begin
        if ($urandom_range(0, sb.finished ? 6 : 60) == 0) send(start_item());
        else if ($urandom_range(0, 99) < 80) send(still_item());
        else send(noise_item());
      end
      drain();
    end

    $display("tb_top: %0d items, %0d results; accepted %0d rejected %0d motion %0d",
             n_items, n_results, sb.seen[0], sb.seen[1], sb.seen[2]);
    $display("tb_top: round retries %0d, calibrations done %0d, empty rounds %0d",
             sb.seen[3], sb.seen[4], sb.seen[5]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
